@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the timer bank modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("timer bank assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("timer bank forbidden condition seen");

`endif

@@ rtl/core/etb_pkg.sv @@
// Shared constants, types and register map of the timer bank.
package etb_pkg;

	localparam int TIMER_COUNT = 8;
	localparam int COUNT_WIDTH = 32;
	localparam int ADDR_W = 12;
	localparam int DATA_W = 32;
	localparam int OP_W = 2;
	localparam int TICK_W = 8;
	localparam int IRQ_W = 8;
	localparam int OFF_W = 5;
	localparam int CTRL_W = 3;

	localparam logic [OP_W-1:0] OP_READ = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [ADDR_W-1:0] SLOT_SIZE = 12'h014;
	localparam logic [ADDR_W-1:0] SHARED_MASKED = 12'h0A0;
	localparam logic [ADDR_W-1:0] SHARED_CLEAR = 12'h0A4;
	localparam logic [ADDR_W-1:0] SHARED_RAW = 12'h0A8;

	localparam logic [OFF_W-1:0] OFF_LOAD = 5'h00;
	localparam logic [OFF_W-1:0] OFF_COUNT = 5'h04;
	localparam logic [OFF_W-1:0] OFF_CTRL = 5'h08;
	localparam logic [OFF_W-1:0] OFF_EOI = 5'h0C;
	localparam logic [OFF_W-1:0] OFF_STAT = 5'h10;

	localparam int CTL_EN = 0;
	localparam int CTL_USER = 1;
	localparam int CTL_MASK = 2;

	typedef enum logic [3:0] {
		REG_NONE,
		REG_LOAD,
		REG_COUNT,
		REG_CTRL,
		REG_EOI,
		REG_STAT,
		REG_ALL_STAT,
		REG_CLEAR_ALL,
		REG_RAW_STAT
	} reg_kind_t;

	typedef struct packed {
		logic [TIMER_COUNT-1:0] sel;
		reg_kind_t kind;
		logic is_read;
		logic is_write;
		logic is_tick;
		logic bad;
	} dec_t;

	typedef struct packed {
		logic wr_load;
		logic wr_ctrl;
		logic clear;
		logic tick;
	} tmr_cmd_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] count;
		logic [COUNT_WIDTH-1:0] load;
		logic [CTRL_W-1:0] ctrl;
		logic raw;
		logic pending;
	} tmr_state_t;

endpackage

@@ rtl/core/etb_decode.sv @@
// Register map decoder: turns an operation and byte offset into a target.
module etb_decode (
	input  logic [etb_pkg::OP_W-1:0]   op,
	input  logic [etb_pkg::ADDR_W-1:0] access_addr,
	output etb_pkg::dec_t              dec
);

	logic is_bus;
	logic [etb_pkg::TIMER_COUNT-1:0] hit;
	logic [etb_pkg::OFF_W-1:0] off;
	logic [etb_pkg::ADDR_W-1:0] base;
	etb_pkg::reg_kind_t kind;

	always_comb begin
		hit = '0;
		off = '0;
		base = '0;
		for (int i = 0; i < etb_pkg::TIMER_COUNT; i++) begin
			base = etb_pkg::ADDR_W'(i * 20);
			if (access_addr >= base && access_addr < base + etb_pkg::SLOT_SIZE) begin
				hit[i] = 1'b1;
				off = off | etb_pkg::OFF_W'(access_addr - base);
			end
		end
	end

	always_comb begin
		is_bus = (op == etb_pkg::OP_READ) || (op == etb_pkg::OP_WRITE);
		kind = etb_pkg::REG_NONE;
		if (|hit) begin
			unique case (off)
				etb_pkg::OFF_LOAD:  kind = etb_pkg::REG_LOAD;
				etb_pkg::OFF_COUNT: kind = etb_pkg::REG_COUNT;
				etb_pkg::OFF_CTRL:  kind = etb_pkg::REG_CTRL;
				etb_pkg::OFF_EOI:   kind = etb_pkg::REG_EOI;
				etb_pkg::OFF_STAT:  kind = etb_pkg::REG_STAT;
				default:            kind = etb_pkg::REG_NONE;
			endcase
		end else if (access_addr == etb_pkg::SHARED_MASKED) begin
			kind = etb_pkg::REG_ALL_STAT;
		end else if (access_addr == etb_pkg::SHARED_CLEAR) begin
			kind = etb_pkg::REG_CLEAR_ALL;
		end else if (access_addr == etb_pkg::SHARED_RAW) begin
			kind = etb_pkg::REG_RAW_STAT;
		end
		// only load and control words take writes
		if (op == etb_pkg::OP_WRITE && kind != etb_pkg::REG_LOAD && kind != etb_pkg::REG_CTRL)
			kind = etb_pkg::REG_NONE;
		if (!is_bus)
			kind = etb_pkg::REG_NONE;

		dec.kind = kind;
		dec.sel = (kind == etb_pkg::REG_NONE) ? '0 : hit;
		dec.is_read = op == etb_pkg::OP_READ;
		dec.is_write = op == etb_pkg::OP_WRITE;
		dec.is_tick = op == etb_pkg::OP_TICK;
		dec.bad = is_bus && kind == etb_pkg::REG_NONE;
	end

endmodule

@@ rtl/core/etb_timer.sv @@
// One down-counting timer with its load, control and status flags.
module etb_timer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  etb_pkg::tmr_cmd_t               cmd,
	input  logic [etb_pkg::DATA_W-1:0]      wdata,
	output etb_pkg::tmr_state_t             state,
	output logic                            pending_d
);

	`include "assert_macros.svh"

	logic [etb_pkg::COUNT_WIDTH-1:0] count_q, count_d;
	logic [etb_pkg::COUNT_WIDTH-1:0] load_q, load_d;
	logic [etb_pkg::CTRL_W-1:0] ctrl_q, ctrl_d;
	logic raw_q, raw_d;
	logic pending_q;
	logic [etb_pkg::CTRL_W-1:0] new_ctrl;

	always_comb begin
		count_d = count_q;
		load_d = load_q;
		ctrl_d = ctrl_q;
		raw_d = raw_q;
		pending_d = pending_q;
		new_ctrl = wdata[etb_pkg::CTRL_W-1:0];
		if (cmd.wr_load) begin
			load_d = wdata[etb_pkg::COUNT_WIDTH-1:0];
			if (ctrl_q[etb_pkg::CTL_EN])
				count_d = wdata[etb_pkg::COUNT_WIDTH-1:0];
		end
		if (cmd.wr_ctrl) begin
			ctrl_d = new_ctrl;
			if (!ctrl_q[etb_pkg::CTL_EN] && new_ctrl[etb_pkg::CTL_EN])
				count_d = load_q;
			if (!new_ctrl[etb_pkg::CTL_EN])
				raw_d = 1'b0;
			if (new_ctrl[etb_pkg::CTL_MASK])
				pending_d = 1'b0;
		end
		if (cmd.clear) begin
			raw_d = 1'b0;
			pending_d = 1'b0;
		end
		if (cmd.tick && ctrl_q[etb_pkg::CTL_EN]) begin
			if (count_q <= etb_pkg::COUNT_WIDTH'(1)) begin
				// expire and reload in the same step
				raw_d = 1'b1;
				if (!ctrl_q[etb_pkg::CTL_MASK])
					pending_d = 1'b1;
				count_d = ctrl_q[etb_pkg::CTL_USER] ? load_q : '1;
			end else begin
				count_d = count_q - etb_pkg::COUNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			load_q <= '0;
			ctrl_q <= '0;
			raw_q <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			count_q <= count_d;
			load_q <= load_d;
			ctrl_q <= ctrl_d;
			raw_q <= raw_d;
			pending_q <= pending_d;
		end
	end

	assign state.count = count_q;
	assign state.load = load_q;
	assign state.ctrl = ctrl_q;
	assign state.raw = raw_q;
	assign state.pending = pending_q;

	`ASSERT_CLK(a_disable_drops_raw, clk, arst_n,
		cmd.wr_ctrl && !cmd.tick && !wdata[etb_pkg::CTL_EN] |=> !raw_q)
	`ASSERT_CLK(a_mask_drops_pending, clk, arst_n,
		cmd.wr_ctrl && wdata[etb_pkg::CTL_MASK] |=> !pending_q)

endmodule

@@ rtl/core/eight_channel_apb_timer_bank.sv @@
// Top level of the eight-channel timer bank: request register, decode, timers, result register.
// Each request (bus read, bus write or clock tick) sits in the request register, where the
// decoder, the timer update logic and the read multiplexer work on it, and its result is
// written into the result register once the output can advance; a new request is taken
// every cycle, and the request register holds only while a finished result is stalled at the
// output. The timers' state changes at the edge where the request moves into the result
// register, so irq_lines shows every pending flag as it stands after that request.
module eight_channel_apb_timer_bank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [etb_pkg::OP_W-1:0]      op,
	input  logic [etb_pkg::ADDR_W-1:0]    access_addr,
	input  logic [etb_pkg::DATA_W-1:0]    write_data,
	input  logic [etb_pkg::TICK_W-1:0]    tick_enables,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [etb_pkg::DATA_W-1:0]    read_data,
	output logic                          bad_offset,
	output logic [etb_pkg::IRQ_W-1:0]     irq_lines
);

	`include "assert_macros.svh"

	logic valid_s1;
	logic [etb_pkg::OP_W-1:0] op_s1;
	logic [etb_pkg::ADDR_W-1:0] addr_s1;
	logic [etb_pkg::DATA_W-1:0] wdata_s1;
	logic [etb_pkg::TICK_W-1:0] ticks_s1;

	logic out_valid_q;
	logic [etb_pkg::DATA_W-1:0] read_data_q;
	logic bad_q;
	logic [etb_pkg::IRQ_W-1:0] irq_q;

	logic advance, upd;
	etb_pkg::dec_t dec;
	etb_pkg::tmr_cmd_t cmd [etb_pkg::TIMER_COUNT];
	etb_pkg::tmr_state_t tstate [etb_pkg::TIMER_COUNT];
	logic [etb_pkg::TIMER_COUNT-1:0] pend_d, pend_q, raw_q;
	logic [etb_pkg::DATA_W-1:0] rdata;
	logic [etb_pkg::DATA_W-1:0] sel_load, sel_count, sel_ctrl, sel_stat;
	logic [etb_pkg::IRQ_W-1:0] irq_d;

	assign advance = !out_valid_q || !out_stall;
	assign upd = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	etb_decode u_decode (
		.op          (op_s1),
		.access_addr (addr_s1),
		.dec         (dec)
	);

	for (genvar g = 0; g < etb_pkg::TIMER_COUNT; g++) begin : g_timer
		assign cmd[g].wr_load = upd && dec.is_write && dec.sel[g] &&
			dec.kind == etb_pkg::REG_LOAD;
		assign cmd[g].wr_ctrl = upd && dec.is_write && dec.sel[g] &&
			dec.kind == etb_pkg::REG_CTRL;
		assign cmd[g].clear = upd && dec.is_read &&
			((dec.sel[g] && dec.kind == etb_pkg::REG_EOI) ||
			 dec.kind == etb_pkg::REG_CLEAR_ALL);
		assign cmd[g].tick = upd && dec.is_tick && ticks_s1[g];

		etb_timer u_timer (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd[g]),
			.wdata     (wdata_s1),
			.state     (tstate[g]),
			.pending_d (pend_d[g])
		);

		assign pend_q[g] = tstate[g].pending;
		assign raw_q[g] = tstate[g].raw;
	end

	// read mux: at most one timer is selected
	always_comb begin
		sel_load = '0;
		sel_count = '0;
		sel_ctrl = '0;
		sel_stat = '0;
		for (int i = 0; i < etb_pkg::TIMER_COUNT; i++) begin
			if (dec.sel[i]) begin
				sel_load = sel_load | etb_pkg::DATA_W'(tstate[i].load);
				sel_count = sel_count | etb_pkg::DATA_W'(tstate[i].count);
				sel_ctrl = sel_ctrl | etb_pkg::DATA_W'(tstate[i].ctrl);
				sel_stat = sel_stat | etb_pkg::DATA_W'(tstate[i].pending);
			end
		end
		rdata = '0;
		if (dec.is_read) begin
			unique case (dec.kind)
				etb_pkg::REG_LOAD:     rdata = sel_load;
				etb_pkg::REG_COUNT:    rdata = sel_count;
				etb_pkg::REG_CTRL:     rdata = sel_ctrl;
				etb_pkg::REG_STAT:     rdata = sel_stat;
				etb_pkg::REG_ALL_STAT: rdata = etb_pkg::DATA_W'(pend_q);
				etb_pkg::REG_RAW_STAT: rdata = etb_pkg::DATA_W'(raw_q);
				default:               rdata = '0;
			endcase
		end
		irq_d = '0;
		irq_d[etb_pkg::TIMER_COUNT-1:0] = pend_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op;
			addr_s1 <= access_addr;
			wdata_s1 <= write_data;
			ticks_s1 <= tick_enables;
		end
		if (upd) begin
			read_data_q <= rdata;
			bad_q <= dec.bad;
			irq_q <= irq_d;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign bad_offset = bad_q;
	assign irq_lines = irq_q;

	`ASSERT_CLK(a_stall_only_when_full, clk, arst_n,
		in_stall |-> valid_s1 && out_valid_q && out_stall)
	`ASSERT_NEVER(a_bad_returns_zero, clk, arst_n,
		out_valid_q && bad_q && read_data_q != '0)
	`ASSERT_CLK(a_clear_all_drops_irq, clk, arst_n,
		upd && dec.is_read && dec.kind == etb_pkg::REG_CLEAR_ALL |=> irq_lines == '0)

endmodule
